[src/mwse_pkg.sv]
// ============================================================================
// mwse_pkg
// Shared types and constants for the multi-word Soundex encoder: the job
// record that the front end hands to the output serializer.
// ============================================================================
package mwse_pkg;

    // Most result bytes one input byte can cause
    localparam int JOB_BYTES = 6;
    localparam int JOB_CNT_W = $clog2(JOB_BYTES + 1);
    localparam int JOB_IDX_W = $clog2(JOB_BYTES);

    // Job queue depth between front end and serializer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;

    // Result bytes of one input byte, in output order; term marks that the
    // final byte is the string terminator
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] chars;
        logic [JOB_CNT_W-1:0]      count;
        logic                      term;
    } t_job;

endpackage

[src/mwse_if.sv]
// ============================================================================
// mwse_if
// Valid/ready channel interfaces for the text input and the code output.
// ============================================================================
interface mwse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface mwse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

[src/mwse_front.sv]
// ============================================================================
// mwse_front
// Accepts text bytes, tracks word state and budget, and turns each byte into
// a job listing the result bytes it causes.
// ============================================================================
module mwse_front #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    input  logic [12:0]         i_capacity,
    output logic                o_push,
    output mwse_pkg::t_job      o_job,
    input  logic                i_full
);
    import mwse_pkg::*;

    localparam int BW = $clog2(MAX_CAPACITY + 1);
    localparam int CW = (BW > 13) ? BW : 13;

    localparam logic [1:0] PH_BEFORE  = 2'd0;
    localparam logic [1:0] PH_WORD    = 2'd1;
    localparam logic [1:0] PH_BETWEEN = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Soundex digit for a letter, or NUL when the letter is not coded
    function automatic logic [7:0] letter_code(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        case (l)
            "b", "f", "p", "v":                     letter_code = 8'h31;
            "c", "g", "j", "k", "q", "s", "x", "z": letter_code = 8'h32;
            "d", "t":                               letter_code = 8'h33;
            "l":                                    letter_code = 8'h34;
            "m", "n":                               letter_code = 8'h35;
            "r":                                    letter_code = 8'h36;
            default:                                letter_code = CH_NUL;
        endcase
    endfunction

    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_dc, n_dc;
    logic [BW-1:0] r_budget, n_budget;
    logic [7:0]    r_prev, n_prev;
    logic          r_afl, n_afl;

    logic                      w_accept;
    logic                      w_alpha;
    logic                      w_drop;
    logic                      w_do_pad;
    logic                      w_clr_dc;
    logic [7:0]                w_upper;
    logic [7:0]                w_code;
    logic [1:0]                w_need;
    logic [1:0]                w_npad;
    logic [CW-1:0]             w_cap;
    logic [JOB_IDX_W:0]        w_k;
    logic [JOB_BYTES-1:0][7:0] w_chars;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    assign w_alpha = ((i_char >= "A") && (i_char <= "Z")) ||
                     ((i_char >= "a") && (i_char <= "z"));
    assign w_upper = ((i_char >= "a") && (i_char <= "z")) ? (i_char - 8'd32) : i_char;
    assign w_code  = letter_code(i_char);
    assign w_cap   = (CW'(i_capacity) > CW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY)
                                                            : CW'(i_capacity);

    // Byte classification and result list
    always_comb begin
        n_phase  = r_phase;
        n_dc     = r_dc;
        n_budget = r_budget;
        n_prev   = r_prev;
        n_afl    = r_afl;
        w_k      = '0;
        w_chars  = '0;
        w_drop   = 1'b0;
        w_do_pad = 1'b0;
        w_clr_dc = 1'b0;
        w_need   = 2'd0;
        w_npad   = 2'd0;

        if (i_char != CH_NUL) begin
            if ((r_phase == PH_WORD) || (r_phase == PH_BETWEEN)) begin
                w_drop = !r_afl && (i_char == r_prev);
                n_afl  = 1'b0;
                n_prev = i_char;
                if (!w_drop && (r_budget != '0)) begin
                    if (r_phase == PH_WORD) begin
                        if (w_alpha) begin
                            if ((w_code != CH_NUL) && (r_dc != 2'd3)) begin
                                w_chars[w_k[JOB_IDX_W-1:0]] = w_code;
                                w_k      = w_k + 1'b1;
                                n_budget = n_budget - 1'b1;
                                n_dc     = n_dc + 2'd1;
                            end
                        end else begin
                            w_do_pad = 1'b1;
                            w_clr_dc = 1'b1;
                            n_phase  = PH_BETWEEN;
                        end
                    end else if (w_alpha) begin
                        w_chars[w_k[JOB_IDX_W-1:0]] = CH_COMMA;
                        w_k      = w_k + 1'b1;
                        n_budget = n_budget - 1'b1;
                        if (n_budget != '0) begin
                            w_chars[w_k[JOB_IDX_W-1:0]] = w_upper;
                            w_k      = w_k + 1'b1;
                            n_budget = n_budget - 1'b1;
                        end
                        n_dc    = 2'd0;
                        n_phase = PH_WORD;
                    end
                end
            end else if (w_alpha) begin
                if (w_cap >= CW'(4)) begin
                    w_chars[w_k[JOB_IDX_W-1:0]] = w_upper;
                    w_k      = w_k + 1'b1;
                    n_budget = BW'(w_cap - CW'(2));
                end else begin
                    n_budget = '0;
                end
                n_phase = PH_WORD;
                n_dc    = 2'd0;
                n_afl   = 1'b1;
                n_prev  = i_char;
            end
        end

        // Closing a word pads its digits with zeros; the phase is the one
        // this byte leaves behind
        if (i_last && (n_phase == PH_WORD)) begin
            w_do_pad = 1'b1;
        end
        if (w_do_pad) begin
            w_need = 2'd3 - n_dc;
            w_npad = (n_budget < BW'(w_need)) ? n_budget[1:0] : w_need;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < w_npad) begin
                    w_chars[3'(w_k + (JOB_IDX_W + 1)'(i))] = CH_ZERO;
                end
            end
            w_k      = w_k + (JOB_IDX_W + 1)'(w_npad);
            n_budget = n_budget - BW'(w_npad);
            n_dc     = n_dc + w_npad;
        end
        if (w_clr_dc) begin
            n_dc = 2'd0;
        end

        // Terminator and string state clear
        if (i_last) begin
            w_chars[w_k[JOB_IDX_W-1:0]] = CH_NUL;
            w_k      = w_k + 1'b1;
            n_phase  = PH_BEFORE;
            n_dc     = 2'd0;
            n_budget = '0;
            n_prev   = CH_NUL;
            n_afl    = 1'b0;
        end
    end

    assign o_push      = w_accept && (w_k != '0);
    assign o_job.chars = w_chars;
    assign o_job.count = JOB_CNT_W'(w_k);
    assign o_job.term  = i_last;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BEFORE;
            r_dc     <= 2'd0;
            r_budget <= '0;
            r_prev   <= CH_NUL;
            r_afl    <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_dc     <= n_dc;
            r_budget <= n_budget;
            r_prev   <= n_prev;
            r_afl    <= n_afl;
        end
    end

    // A job never holds more bytes than the record carries
    a_job_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.count != '0) && (o_job.count <= JOB_CNT_W'(JOB_BYTES)))
        else $error("front job byte count out of range");

    // Digits only ever count while inside or between words
    a_dc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BEFORE) |-> (r_dc == 2'd0) && (r_budget == '0))
        else $error("front word state left over before first word");

    // A terminator in the input always produces a job
    a_last_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |-> o_push)
        else $error("front dropped a string terminator");

endmodule

[src/mwse_queue.sv]
// ============================================================================
// mwse_queue
// Short job queue between the front end and the output serializer.
// ============================================================================
module mwse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mwse_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mwse_pkg::t_job o_head
);
    import mwse_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr == r_rd) == (o_empty || o_full))
        else $error("queue pointers disagree with fill count");

endmodule

[src/mwse_back.sv]
// ============================================================================
// mwse_back
// Output serializer: walks the head job byte by byte into the output register,
// one result transaction per cycle while a job waits and the output is ready.
// ============================================================================
module mwse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mwse_pkg::t_job i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last
);
    import mwse_pkg::*;

    logic [JOB_IDX_W-1:0] r_idx;
    logic                 r_ov;
    logic [7:0]           r_char;
    logic                 r_last;

    logic w_load;
    logic w_end;

    assign w_load = !r_ov || i_ready;
    assign w_end  = (JOB_CNT_W'(r_idx) == (i_head.count - 1'b1));
    assign o_pop  = w_load && !i_empty && w_end;

    // Byte index within the head job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else if (w_load) begin
            r_ov <= !i_empty;
            if (!i_empty) begin
                r_idx <= w_end ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_char <= i_head.chars[r_idx];
            r_last <= i_head.term && w_end;
        end
    end

    assign o_valid = r_ov;
    assign o_char  = r_char;
    assign o_last  = r_last;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (JOB_CNT_W'(r_idx) < i_head.count))
        else $error("serializer index past end of job");

    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_idx == '0))
        else $error("serializer index not at start with no job");

    a_term_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_char == CH_NUL))
        else $error("terminator transaction carries a nonzero byte");

endmodule

[src/multi_word_soundex_encoder.sv]
// ============================================================================
// multi_word_soundex_encoder
// Streams text bytes in and Soundex codes (comma separated, zero terminated)
// out, with an APB register for the output capacity.
// ============================================================================
// One input byte is accepted per cycle whenever the four-entry job queue has
// room; the front end decides in that same cycle every result byte the input
// byte causes (zero to six). The output serializer sends one result byte per
// cycle while the output is ready, so the sustained rate is then one input
// byte per cycle as long as the bytes average at most one result byte each;
// longer bursts (word padding, comma plus letter, terminator) fill the queue
// and stall the input through ready. A result byte is held in a job queue
// entry and then in the output register on its way out. The capacity register
// (byte address 0, 13 bits, reset 256) is sampled at each string's first
// letter and limited to MAX_CAPACITY; write it only while the block is idle.
module multi_word_soundex_encoder #(
    parameter int MAX_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwse_in_if.sink     i_in,
    mwse_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwse_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    logic [12:0] r_capacity;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_job  w_job;
    t_job  w_head;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 13'd256;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[12:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {19'd0, r_capacity} : 32'd0;

    // Front end: classify bytes, build jobs
    mwse_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_char     (i_in.in_char),
        .i_last     (i_in.in_last),
        .i_capacity (r_capacity),
        .o_push     (w_push),
        .o_job      (w_job),
        .i_full     (w_full)
    );

    // Job queue
    mwse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Output serializer
    mwse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_char  (o_out.out_char),
        .o_last  (o_out.out_last)
    );

endmodule
